FILE: rtl/hkrd_pkg.sv
// Shared types and constants for the keyboard report event decoder.
package hkrd_pkg;

    localparam int          MOD_BITS      = 8;
    localparam int          INPUT_SLOTS   = 6;
    localparam int          MAX_RESULTS   = 20;
    localparam int          CNT_W         = $clog2(MAX_RESULTS + 1);
    localparam logic [7:0]  MOD_BASE      = 8'hE0;
    localparam logic [7:0]  ROLLOVER_CODE = 8'h01;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_REPEAT  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_MOD,
        PH_PRESS,
        PH_RELEASE,
        PH_REPEAT
    } phase_t;

    typedef struct packed {
        logic   load;
        logic   step;
        phase_t phase;
        logic   commit;
        logic   flush;
    } cmd_t;

    typedef struct packed {
        logic step_ok;
        logic roll;
        logic flush_done;
    } status_t;

endpackage

FILE: rtl/hkrd_ctrl.sv
// Scan sequencer: walks modifier bits, press slots, release slots and the repeat check.
module hkrd_ctrl #(
    parameter int KEY_SLOTS = 6,
    parameter int IDX_W     = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_report_ok,
    output logic             s_ready,
    input  hkrd_pkg::status_t status,
    output hkrd_pkg::cmd_t    cmd,
    output logic [IDX_W-1:0] idx
);
    import hkrd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_PRESS,
        ST_RELEASE,
        ST_REPEAT,
        ST_FLUSH
    } state_t;

    localparam logic [IDX_W-1:0] MOD_LAST  = IDX_W'(MOD_BITS - 1);
    localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(KEY_SLOTS - 1);

    state_t           state_reg;
    logic [IDX_W-1:0] idx_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign idx     = idx_reg;

    always_comb begin
        cmd        = '0;
        cmd.phase  = PH_MOD;
        cmd.load   = (state_reg == ST_IDLE) && s_valid && s_report_ok;
        cmd.flush  = (state_reg == ST_FLUSH);
        case (state_reg)
            ST_MOD: begin
                cmd.step  = 1'b1;
                cmd.phase = PH_MOD;
            end
            ST_PRESS: begin
                cmd.step  = 1'b1;
                cmd.phase = PH_PRESS;
            end
            ST_RELEASE: begin
                cmd.step  = 1'b1;
                cmd.phase = PH_RELEASE;
            end
            ST_REPEAT: begin
                cmd.step   = 1'b1;
                cmd.phase  = PH_REPEAT;
                cmd.commit = status.step_ok;
            end
            default: begin
                cmd.step = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    idx_reg <= '0;
                    if (s_valid && s_report_ok) begin
                        state_reg <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    if (status.step_ok) begin
                        if (idx_reg == MOD_LAST) begin
                            idx_reg <= '0;
                            // A roll-over report ends after its modifier events.
                            state_reg <= status.roll ? ST_FLUSH : ST_PRESS;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                ST_PRESS: begin
                    if (status.step_ok) begin
                        if (idx_reg == SLOT_LAST) begin
                            idx_reg   <= '0;
                            state_reg <= ST_RELEASE;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                ST_RELEASE: begin
                    if (status.step_ok) begin
                        if (idx_reg == SLOT_LAST) begin
                            idx_reg   <= '0;
                            state_reg <= ST_REPEAT;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                ST_REPEAT: begin
                    if (status.step_ok) begin
                        state_reg <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    if (status.flush_done) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/hkrd_datapath.sv
// Report and previous-state registers, event evaluation, pending event and output register.
module hkrd_datapath #(
    parameter int KEY_SLOTS = 6,
    parameter int IDX_W     = 3
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  hkrd_pkg::cmd_t                         cmd,
    input  logic [IDX_W-1:0]                       idx,
    output hkrd_pkg::status_t                      status,
    input  logic [7:0]                             modifiers,
    input  logic [hkrd_pkg::INPUT_SLOTS-1:0][7:0]  slots,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [7:0]                             m_usage_code,
    output logic [1:0]                             m_event_kind,
    output logic                                   m_last_event
);
    import hkrd_pkg::*;

    localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    logic [KEY_SLOTS-1:0][7:0] slot_pad;
    logic [KEY_SLOTS-1:0][7:0] cur_reg;
    logic [KEY_SLOTS-1:0][7:0] prev_keys_reg;
    logic [7:0]                mod_reg;
    logic [7:0]                prev_mod_reg;
    logic                      any_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      pend_valid_reg;
    logic [7:0]                pend_code_reg;
    kind_t                     pend_kind_reg;
    logic                      m_valid_reg;
    logic [7:0]                m_code_reg;
    kind_t                     m_kind_reg;
    logic                      m_last_reg;

    logic [SLOT_W-1:0] sidx;
    logic [2:0]        midx;
    logic [7:0]        cur_sel;
    logic [7:0]        prev_sel;
    logic              in_prev;
    logic              in_cur;
    logic              roll;
    logic              rep_key_found;
    logic [7:0]        rep_key;
    logic [7:0]        rep_mod;
    logic              hit;
    logic [7:0]        ev_code;
    kind_t             ev_kind;
    logic              room;
    logic              need_push;
    logic              out_free;
    logic              do_step;
    logic              push_ev;
    logic              take_ev;
    logic              flush_push;

    // Slots beyond the report's six fields read as empty.
    for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_pad
        if (g < INPUT_SLOTS) begin : g_in
            assign slot_pad[g] = slots[g];
        end else begin : g_zero
            assign slot_pad[g] = '0;
        end
    end

    assign sidx     = idx[SLOT_W-1:0];
    assign midx     = idx[2:0];
    assign cur_sel  = cur_reg[sidx];
    assign prev_sel = prev_keys_reg[sidx];

    always_comb begin
        in_prev = 1'b0;
        in_cur  = 1'b0;
        roll    = 1'b1;
        for (int j = 0; j < KEY_SLOTS; j++) begin
            if (prev_keys_reg[j] == cur_sel) in_prev = 1'b1;
            if (cur_reg[j] == prev_sel)      in_cur  = 1'b1;
            if (cur_reg[j] != ROLLOVER_CODE) roll    = 1'b0;
        end
    end

    // Highest nonzero slot and lowest set modifier for the repeat event.
    always_comb begin
        rep_key_found = 1'b0;
        rep_key       = '0;
        rep_mod       = MOD_BASE;
        for (int j = 0; j < KEY_SLOTS; j++) begin
            if (cur_reg[j] != '0) begin
                rep_key_found = 1'b1;
                rep_key       = cur_reg[j];
            end
        end
        for (int b = MOD_BITS - 1; b >= 0; b--) begin
            if (mod_reg[b]) rep_mod = MOD_BASE + 8'(b);
        end
    end

    always_comb begin
        hit     = 1'b0;
        ev_code = cur_sel;
        ev_kind = KIND_PRESS;
        case (cmd.phase)
            PH_MOD: begin
                hit     = mod_reg[midx] ^ prev_mod_reg[midx];
                ev_code = MOD_BASE + 8'(midx);
                ev_kind = mod_reg[midx] ? KIND_PRESS : KIND_RELEASE;
            end
            PH_PRESS: begin
                hit     = (cur_sel != '0) && !in_prev;
                ev_code = cur_sel;
                ev_kind = KIND_PRESS;
            end
            PH_RELEASE: begin
                hit     = (prev_sel != '0) && !in_cur;
                ev_code = prev_sel;
                ev_kind = KIND_RELEASE;
            end
            PH_REPEAT: begin
                hit     = !any_reg && (rep_key_found || (mod_reg != '0));
                ev_code = rep_key_found ? rep_key : rep_mod;
                ev_kind = KIND_REPEAT;
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

    // Events past the result limit are dropped but still count as produced.
    assign room       = (cnt_reg < CNT_W'(MAX_RESULTS));
    assign out_free   = !m_valid_reg || m_ready;
    assign need_push  = hit && room && pend_valid_reg;
    assign do_step    = cmd.step && (!need_push || out_free);
    assign push_ev    = do_step && need_push;
    assign take_ev    = do_step && hit && room;
    assign flush_push = cmd.flush && pend_valid_reg && out_free;

    assign status.step_ok    = !need_push || out_free;
    assign status.roll       = roll;
    assign status.flush_done = !pend_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_reg <= slot_pad;
            mod_reg <= modifiers;
        end
        if (take_ev) begin
            pend_code_reg <= ev_code;
            pend_kind_reg <= ev_kind;
        end
        if (push_ev || flush_push) begin
            m_code_reg <= pend_code_reg;
            m_kind_reg <= pend_kind_reg;
            m_last_reg <= flush_push;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_mod_reg   <= '0;
            prev_keys_reg  <= '0;
            any_reg        <= 1'b0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.commit) begin
                prev_mod_reg  <= mod_reg;
                prev_keys_reg <= cur_reg;
            end
            if (cmd.load) begin
                any_reg <= 1'b0;
                cnt_reg <= '0;
            end else begin
                if (do_step && hit) any_reg <= 1'b1;
                if (take_ev)        cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.load) begin
                pend_valid_reg <= 1'b0;
            end else if (take_ev) begin
                pend_valid_reg <= 1'b1;
            end else if (flush_push) begin
                pend_valid_reg <= 1'b0;
            end
            if (push_ev || flush_push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_usage_code = m_code_reg;
    assign m_event_kind = m_kind_reg;
    assign m_last_event = m_last_reg;

`ifndef SYNTHESIS
    a_cnt_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("event count exceeded the result limit");

    a_pend_counted : assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (cnt_reg != '0))
        else $error("pending event without a counted event");

    a_no_event_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        !any_reg |-> (cnt_reg == '0) && !pend_valid_reg)
        else $error("event recorded while no event was produced");

    a_flush_empties : assert property (@(posedge aclk) disable iff (!aresetn)
        flush_push |=> !pend_valid_reg && m_valid_reg && m_last_reg)
        else $error("final event not moved to the output register");
`endif

endmodule

FILE: rtl/hid_keyboard_report_event_decoder.sv
// Boot keyboard report decoder: each accepted transaction on s_ is one report (a
// modifier byte and six key-slot bytes); the block compares it against the previously
// stored report and emits one key event per m_ transaction: modifier presses and
// releases (usage 0xE0 plus bit), then presses of new slot codes, then releases of
// codes that are gone, or a single repeat event when nothing changed and a key or
// modifier is held; m_last_event marks the final event of a report and at most 20
// events are emitted per report. A report with s_report_ok low is accepted while idle
// and produces nothing. An OK report keeps s_ready low until its scan and flush are
// done and while the result side stalls, as a single sequencer checks one modifier
// bit or one key slot per cycle unless stalled. A roll-over report (all slots 0x01)
// stops after the modifier scan and leaves the stored report unchanged.
module hid_keyboard_report_event_decoder #(
    parameter int KEY_SLOTS = 6
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_report_ok,
    input  logic [7:0] s_modifiers,
    input  logic [7:0] s_key_slot_0,
    input  logic [7:0] s_key_slot_1,
    input  logic [7:0] s_key_slot_2,
    input  logic [7:0] s_key_slot_3,
    input  logic [7:0] s_key_slot_4,
    input  logic [7:0] s_key_slot_5,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_usage_code,
    output logic [1:0] m_event_kind,
    output logic       m_last_event
);
    import hkrd_pkg::*;

    localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int IDX_W  = (SLOT_W > 3) ? SLOT_W : 3;

    cmd_t                        cmd;
    status_t                     status;
    logic [IDX_W-1:0]            idx;
    logic [INPUT_SLOTS-1:0][7:0] slots;

    assign slots[0] = s_key_slot_0;
    assign slots[1] = s_key_slot_1;
    assign slots[2] = s_key_slot_2;
    assign slots[3] = s_key_slot_3;
    assign slots[4] = s_key_slot_4;
    assign slots[5] = s_key_slot_5;

    hkrd_ctrl #(
        .KEY_SLOTS (KEY_SLOTS),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_report_ok (s_report_ok),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd),
        .idx         (idx)
    );

    hkrd_datapath #(
        .KEY_SLOTS (KEY_SLOTS),
        .IDX_W     (IDX_W)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .idx          (idx),
        .status       (status),
        .modifiers    (s_modifiers),
        .slots        (slots),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_usage_code (m_usage_code),
        .m_event_kind (m_event_kind),
        .m_last_event (m_last_event)
    );

endmodule
